// ----- hdl/smf_pkg.sv -----
// package: shared constants and control types for the sliding window median filter
`timescale 1ns / 1ps
`default_nettype none
package smf_pkg;

    localparam int SMF_MAX_HALF_WINDOW = 16;
    localparam int SMF_SAMPLE_BITS     = 16;
    localparam int SMF_HALF_BITS       = 5;
    localparam logic [SMF_HALF_BITS-1:0] SMF_HALF_RESET = 5'd4;

    typedef struct packed {
        logic load;
        logic clear;
        logic flush;
        logic full;
    } smf_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/smf_cell.sv -----
// sorted window cell: one slot of the ordered sample chain with its age tag
`timescale 1ns / 1ps
`default_nettype none
module smf_cell
    import smf_pkg::*;
#(
    parameter int SAMPLE_BITS = SMF_SAMPLE_BITS,
    parameter int AGE_W       = 5
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  smf_ctrl_t                     ctrl,
    input  wire signed [SAMPLE_BITS-1:0]  new_sample,
    input  wire        [AGE_W-1:0]        oldest_age,
    input  wire signed [SAMPLE_BITS-1:0]  left_value,
    input  wire        [AGE_W-1:0]        left_age,
    input  wire                           left_valid,
    input  wire                           left_gt,
    input  wire                           left_del,
    input  wire signed [SAMPLE_BITS-1:0]  right_value,
    input  wire        [AGE_W-1:0]        right_age,
    input  wire                           right_valid,
    input  wire                           right_gt,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic        [AGE_W-1:0]       age,
    output logic                          valid,
    output logic                          gt,
    output logic                          del
);

    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic        [AGE_W-1:0]       age_reg, age_next;
    logic                          valid_reg, valid_next;

    logic signed [SAMPLE_BITS-1:0] b_value, bl_value;
    logic        [AGE_W-1:0]       b_age, bl_age;
    logic                          b_valid, bl_valid, b_gt, bl_gt;

    always_comb begin
        valid = valid_reg & ~ctrl.clear;
        value = value_reg;
        age   = age_reg;
        gt    = ~valid | (value_reg > new_sample);
        del   = left_del | (ctrl.full & valid & (age_reg == oldest_age));

        // view after removing the oldest sample
        b_value  = del ? right_value : value_reg;
        b_age    = del ? right_age   : age_reg;
        b_valid  = del ? right_valid : valid;
        b_gt     = del ? right_gt    : gt;
        bl_value = left_del ? value_reg : left_value;
        bl_age   = left_del ? age_reg   : left_age;
        bl_valid = left_del ? valid     : left_valid;
        bl_gt    = left_del ? gt        : left_gt;

        if (!b_gt) begin
            value_next = b_value;
            age_next   = b_age + AGE_W'(1);
            valid_next = b_valid;
        end else if (!bl_gt) begin
            value_next = new_sample;
            age_next   = '0;
            valid_next = 1'b1;
        end else begin
            value_next = bl_value;
            age_next   = bl_age + AGE_W'(1);
            valid_next = bl_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.flush) begin
            valid_reg <= 1'b0;
        end else if (ctrl.load) begin
            valid_reg <= valid_next;
        end
        if (ctrl.load) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sliding_window_median_filter_top.sv -----
// top level: sorted cell chain, fill tracking and median output stage
//
//  channel  | direction | payload
//  s_       | in        | tdata: sample ; tuser: first_sample
//  m_       | out       | tdata: median_times_two ; tuser: window_full
//  cfg_     | in        | data: half_window
//
//  one sample per cycle sustained while the m_ side is not stalled; a result passes through
//  the cell chain update followed by the registered middle-pair adder
//  synchronous active-low reset: window empty, half_window 4
//  a stalled m_ side holds one result and one pending update, then drops s_tready
//  a cfg_ write empties the window
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_median_filter_top
    import smf_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = SMF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = SMF_SAMPLE_BITS
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,  // sample
    input  wire                                      s_tuser,  // first_sample
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]         m_tdata,  // median_times_two
    output logic                                     m_tuser,  // window_full
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire  [SMF_HALF_BITS-1:0]                 cfg_data
);

    localparam int DEPTH  = 2 * MAX_HALF_WINDOW;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CMP_W  = (HW_W > SMF_HALF_BITS) ? HW_W : SMF_HALF_BITS;
    localparam int SUM_W  = SAMPLE_BITS + 1;
    localparam int MT_W   = ((SAMPLE_BITS + 8) / 8) * 8;

    logic [SMF_HALF_BITS-1:0] half_reg;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic                     pend_reg, pend_full_reg;
    logic                     m_valid_reg;
    logic signed [SUM_W-1:0]  m_data_reg;
    logic                     m_full_reg;

    logic [CMP_W-1:0] half_ext, eff_half;
    logic [CNT_W-1:0] len_cnt;
    logic [IDX_W-1:0] oldest_age, lo_idx, hi_idx;
    logic             s_xfer, out_free, clear;
    smf_ctrl_t        ctrl;
    logic signed [SAMPLE_BITS-1:0] new_sample;

    logic signed [SAMPLE_BITS-1:0] c_value [DEPTH+1];
    logic        [IDX_W-1:0]       c_age   [DEPTH+1];
    logic                          c_valid [DEPTH+1];
    logic                          c_gt    [DEPTH+1];
    logic                          c_del   [DEPTH];

    logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic signed [SUM_W-1:0]       sum;

    always_comb begin
        half_ext = CMP_W'(half_reg);
        if (half_ext == '0) begin
            eff_half = CMP_W'(1);
        end else if (half_ext > CMP_W'(MAX_HALF_WINDOW)) begin
            eff_half = CMP_W'(MAX_HALF_WINDOW);
        end else begin
            eff_half = half_ext;
        end
        len_cnt    = CNT_W'({eff_half, 1'b0});
        oldest_age = IDX_W'(len_cnt - CNT_W'(1));
        lo_idx     = IDX_W'(eff_half - CMP_W'(1));
        hi_idx     = IDX_W'(eff_half);

        out_free  = ~m_valid_reg | m_tready;
        s_tready  = ~pend_reg | out_free;
        s_xfer    = s_tvalid & s_tready;
        cfg_ready = 1'b1;
        clear     = s_tuser;
        new_sample = s_tdata[SAMPLE_BITS-1:0];

        ctrl.load  = s_xfer;
        ctrl.clear = clear;
        ctrl.flush = cfg_valid;
        ctrl.full  = ~clear & (fill_reg == len_cnt);

        if (clear) begin
            fill_next = CNT_W'(1);
        end else if (fill_reg < len_cnt) begin
            fill_next = fill_reg + CNT_W'(1);
        end else begin
            fill_next = fill_reg;
        end
    end

    // chain boundaries
    assign c_value[DEPTH] = '0;
    assign c_age[DEPTH]   = '0;
    assign c_valid[DEPTH] = 1'b0;
    assign c_gt[DEPTH]    = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] l_value;
            logic        [IDX_W-1:0]       l_age;
            logic                          l_valid, l_gt, l_del;
            if (gi == 0) begin : g_first
                assign l_value = '0;
                assign l_age   = '0;
                assign l_valid = 1'b0;
                assign l_gt    = 1'b0;
                assign l_del   = 1'b0;
            end else begin : g_rest
                assign l_value = c_value[gi-1];
                assign l_age   = c_age[gi-1];
                assign l_valid = c_valid[gi-1];
                assign l_gt    = c_gt[gi-1];
                assign l_del   = c_del[gi-1];
            end
            smf_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_W       (IDX_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_sample  (new_sample),
                .oldest_age  (oldest_age),
                .left_value  (l_value),
                .left_age    (l_age),
                .left_valid  (l_valid),
                .left_gt     (l_gt),
                .left_del    (l_del),
                .right_value (c_value[gi+1]),
                .right_age   (c_age[gi+1]),
                .right_valid (c_valid[gi+1]),
                .right_gt    (c_gt[gi+1]),
                .value       (c_value[gi]),
                .age         (c_age[gi]),
                .valid       (c_valid[gi]),
                .gt          (c_gt[gi]),
                .del         (c_del[gi])
            );
        end
    endgenerate

    // middle pair pick by one-hot and-or
    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lo_idx == IDX_W'(i)) begin
                lo_val = lo_val | c_value[i];
            end
            if (hi_idx == IDX_W'(i)) begin
                hi_val = hi_val | c_value[i];
            end
        end
        sum = SUM_W'(lo_val) + SUM_W'(hi_val);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg      <= SMF_HALF_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_full_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_full_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                half_reg <= cfg_data;
                fill_reg <= '0;
            end else if (s_xfer) begin
                fill_reg <= fill_next;
            end

            if (s_xfer) begin
                pend_reg      <= 1'b1;
                pend_full_reg <= (fill_next == len_cnt);
            end else if (out_free) begin
                pend_reg <= 1'b0;
            end

            if (pend_reg && out_free) begin
                m_valid_reg <= 1'b1;
                m_full_reg  <= pend_full_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (pend_reg && out_free) begin
            m_data_reg <= pend_full_reg ? sum : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MT_W'($unsigned(m_data_reg));
    assign m_tuser  = m_full_reg;

endmodule
`default_nettype wire

// ----- sim/sliding_window_median_filter_top_tb.sv -----
// testbench: random and directed streaming checks of the sliding window median filter
`timescale 1ns / 1ps
module sliding_window_median_filter_top_tb;
    import smf_pkg::*;

    localparam int S_W        = ((SMF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_W        = ((SMF_SAMPLE_BITS + 8) / 8) * 8;
    localparam int WIN_DEPTH  = 2 * SMF_MAX_HALF_WINDOW;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [M_W-1:0] tdata;
        logic           tuser;
    } median_result_t;

    class median_scoreboard;
        int             half_reg;
        int             window[WIN_DEPTH];
        int             fill;
        int             slot;
        median_result_t outstanding[$];
        int             mismatches;

        function new();
            half_reg   = SMF_HALF_RESET;
            fill       = 0;
            slot       = 0;
            mismatches = 0;
        endfunction

        function void set_half(logic [SMF_HALF_BITS-1:0] value);
            half_reg = value;
            fill     = 0;
            slot     = 0;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        // predicts the result for one accepted sample transfer
        function void note_sample(logic [S_W-1:0] raw, logic first);
            int             h;
            int             len;
            int             sorted[WIN_DEPTH];
            int             key;
            int             j;
            int             sum;
            logic [16:0]    sum_bits;
            median_result_t res;
            h = half_reg;
            if (h < 1) h = 1;
            if (h > SMF_MAX_HALF_WINDOW) h = SMF_MAX_HALF_WINDOW;
            len = 2 * h;
            if (first) begin
                fill = 0;
                slot = 0;
            end
            if (slot >= len) slot = 0;
            window[slot] = $signed(raw[SMF_SAMPLE_BITS-1:0]);
            slot++;
            if (slot >= len) slot = 0;
            if (fill < len) fill++;
            res = '0;
            if (fill >= len) begin
                for (int i = 0; i < len; i++) sorted[i] = window[i];
                for (int i = 1; i < len; i++) begin
                    key = sorted[i];
                    j = i;
                    while (j > 0 && sorted[j-1] > key) begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = key;
                end
                sum       = sorted[h-1] + sorted[h];
                sum_bits  = sum[16:0];
                res.tdata = M_W'(sum_bits);
                res.tuser = 1'b1;
            end
            outstanding.push_back(res);
        endfunction

        function void check_result(logic [M_W-1:0] tdata, logic tuser);
            median_result_t want;
            if (outstanding.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tdata %h tuser %b", tdata, tuser);
                return;
            end
            want = outstanding.pop_front();
            if (tdata !== want.tdata || tuser !== want.tuser) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected tdata %h tuser %b, got tdata %h tuser %b",
                             want.tdata, want.tuser, tdata, tuser);
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_W-1:0]           s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_W-1:0]           m_tdata;
    logic                     m_tuser;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [SMF_HALF_BITS-1:0] cfg_data;

    median_scoreboard board;
    bit               idle_on;
    int               stall_left;

    sliding_window_median_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sample
        .s_tuser   (s_tuser),   // first_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // median_times_two
        .m_tuser   (m_tuser),   // window_full
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        idle_on    = 1'b1;
        stall_left = 0;
        board      = new();
    end

    // receiver side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 13);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    initial begin
        repeat (MAX_CYCLES) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_sample(input logic [S_W-1:0] value, input logic first);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(value, first);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_half(input logic [SMF_HALF_BITS-1:0] value);
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_half(value);
    endtask

    function automatic logic [S_W-1:0] pick_sample(int centre);
        int kind;
        int v;
        kind = $urandom_range(0, 19);
        if (kind < 10) begin
            v = $urandom_range(0, 65535);
        end else if (kind < 14) begin
            v = $urandom_range(0, 8) - 4;
        end else if (kind < 17) begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = -1;
                default: v = 0;
            endcase
        end else begin
            v = centre + $urandom_range(0, 64) - 32;
        end
        return v[S_W-1:0];
    endfunction

    initial begin
        int halves[11];
        int centre;
        halves = '{17, 31, 16, 2, 3, 8, 5, 1, 12, 0, 6};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window of eight, extremes and a restart
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0064, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'hfffb, 1'b1);
        send_sample(16'h0003, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);

        // shortest window: largest and smallest sums
        write_half(5'd1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);

        // zero half window behaves as one
        write_half(5'd0);
        send_sample(16'h0007, 1'b0);
        send_sample(16'hfff9, 1'b0);
        send_sample(16'h0003, 1'b1);

        foreach (halves[p]) begin
            if (p == 10) idle_on = 1'b0;
            write_half(halves[p][SMF_HALF_BITS-1:0]);
            centre = $urandom_range(0, 60000) - 30000;
            for (int i = 0; i < 105; i++) begin
                if (p == 3 && i == 50) drain();
                if ($urandom_range(0, 29) == 0) centre = $urandom_range(0, 60000) - 30000;
                send_sample(pick_sample(centre), $urandom_range(0, 59) == 0);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
